>>> hdl/byte_histogram_monte_carlo_pi_defines.svh
// Assertion macros for the byte histogram and pi point counter.
`ifndef BYTE_HISTOGRAM_MONTE_CARLO_PI_DEFINES_SVH
`define BYTE_HISTOGRAM_MONTE_CARLO_PI_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BHMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BHMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bhmc_pkg.sv
// Types and constants shared by the byte histogram and pi point counter.
`timescale 1ns / 1ps
package bhmc_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  localparam int POINT_WIDTH = 45;
  localparam logic [2:0] GROUP_LAST = 3'd7;
  localparam logic [63:0] RADIUS_SQ = 64'hFFFF_FFFE_0000_0001;
  localparam logic [31:0] OUT32_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] OUT48_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [POINT_WIDTH-1:0] POINT_MAX = {POINT_WIDTH{1'b1}};

endpackage

>>> hdl/bhmc_if.sv
// Valid/ready channel interfaces for the sample and result items.
`timescale 1ns / 1ps
interface bhmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       chunk_end;

  modport source (output valid, kind, value, chunk_end, input ready);
  modport sink (input valid, kind, value, chunk_end, output ready);
endinterface

interface bhmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_count;
  logic [47:0] total_bytes;
  logic [44:0] inside_points;
  logic [44:0] total_points;

  modport source (output valid, bin_count, total_bytes, inside_points, total_points,
                  input ready);
  modport sink (input valid, bin_count, total_bytes, inside_points, total_points,
                output ready);
endinterface

>>> hdl/bhmc_point.sv
// Quarter-circle test: registered squares, then exact sum compare.
`timescale 1ns / 1ps
module bhmc_point
  import bhmc_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic        in_circle
);

  logic [63:0] x_sq;
  logic [63:0] y_sq;
  logic [64:0] r_sq;

  always_ff @(posedge clk) begin
    if (load) begin
      x_sq <= x * x;
      y_sq <= y * y;
    end
  end

  assign r_sq      = {1'b0, x_sq} + {1'b0, y_sq};
  assign in_circle = (r_sq <= {1'b0, RADIUS_SQ});

endmodule

>>> hdl/byte_histogram_monte_carlo_pi.sv
// Byte histogram with running byte count and Monte Carlo pi point counter.
//
// sample channel: kind 0 is a data byte in value (chunk_end restarts the
// eight-byte grouping after it), kind 1 reads the bin at value, kind 2
// clears every count and bin. Kind 3 reads like kind 1.
// result channel: one item per sample with the bin count (updated or
// addressed bin), byte total, inside points and total points, saturating.
// Each sample passes through idle, where it is accepted and the histogram
// read is issued, then lookup with the read-modify-write of the bin and the
// squaring of X and Y, then finish with the compare and counter update that
// loads the output register. A new sample is not accepted until the last
// one has left finish, as set by the single-port histogram memory sequence;
// result valid rises when finish loads the output register.
// The output register holds one item; while it is not taken the block still
// accepts and works on one more sample, then waits in the final step.
// Reset (synchronous) clears all bins through per-bin valid flags at once,
// and zeroes the counters and grouping; no clearing pass is needed.
`timescale 1ns / 1ps
module byte_histogram_monte_carlo_pi
  import bhmc_pkg::*;
#(
  parameter int BIN_WIDTH   = 32,
  parameter int TOTAL_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  bhmc_in_if.sink           sample,
  bhmc_out_if.source        result
);

  `include "byte_histogram_monte_carlo_pi_defines.svh"

  state_t state, state_next;

  logic                   accept;
  logic                   load_result;
  logic                   result_valid;

  logic [BIN_WIDTH-1:0]   mem [256];
  logic [BIN_WIDTH-1:0]   rd_data;
  logic [255:0]           bin_valid;
  logic                   hit;
  logic [7:0]             addr;
  kind_t                  kind;
  logic                   is_point;

  logic [7:0]             group_bytes [7];
  logic [2:0]             group_position;
  logic [TOTAL_WIDTH-1:0] byte_total;
  logic [POINT_WIDTH-1:0] inside_total, inside_next;
  logic [POINT_WIDTH-1:0] point_total, point_next;

  logic [31:0]            x, y;
  logic                   in_circle;

  logic [BIN_WIDTH-1:0]   bin_cur, bin_new, bin;
  logic [63:0]            bin_ext, total_ext;

  logic [31:0]            bin_count;
  logic [47:0]            total_bytes;
  logic [44:0]            inside_points;
  logic [44:0]            total_points;

  assign accept = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    load_result  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = !rst;
        if (sample.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!result_valid || result.ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // histogram memory: read at accept, written back in lookup for data bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[sample.value];
    end
    if (state == ST_LOOKUP && kind == KIND_DATA) begin
      mem[addr] <= bin_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr     <= sample.value;
      kind     <= kind_t'(sample.kind);
      hit      <= bin_valid[sample.value];
      is_point <= (kind_t'(sample.kind) == KIND_DATA) && (group_position == GROUP_LAST);
      x        <= {group_bytes[0], group_bytes[1], group_bytes[2], group_bytes[3]};
      y        <= {group_bytes[4], group_bytes[5], group_bytes[6], sample.value};
    end
    if (accept && kind_t'(sample.kind) == KIND_DATA && group_position != GROUP_LAST) begin
      group_bytes[group_position] <= sample.value;
    end
  end

  assign bin_cur = hit ? rd_data : '0;

  always_comb begin
    unique case (kind)
      KIND_DATA:  bin_new = (bin_cur == '1) ? bin_cur : bin_cur + 1'b1;
      KIND_CLEAR: bin_new = '0;
      default:    bin_new = bin_cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      bin <= bin_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid      <= '0;
      group_position <= '0;
      byte_total     <= '0;
    end else if (accept && kind_t'(sample.kind) == KIND_CLEAR) begin
      bin_valid      <= '0;
      group_position <= '0;
      byte_total     <= '0;
    end else begin
      if (accept && kind_t'(sample.kind) == KIND_DATA) begin
        if (byte_total != '1) begin
          byte_total <= byte_total + 1'b1;
        end
        if (sample.chunk_end || group_position == GROUP_LAST) begin
          group_position <= '0;
        end else begin
          group_position <= group_position + 3'd1;
        end
      end
      if (state == ST_LOOKUP && kind == KIND_DATA) begin
        bin_valid[addr] <= 1'b1;
      end
    end
  end

  bhmc_point u_point (
    .clk       (clk),
    .load      (state == ST_LOOKUP),
    .x         (x),
    .y         (y),
    .in_circle (in_circle)
  );

  always_comb begin
    inside_next = inside_total;
    point_next  = point_total;
    if (is_point) begin
      if (in_circle && inside_total != POINT_MAX) begin
        inside_next = inside_total + 1'b1;
      end
      if (point_total != POINT_MAX) begin
        point_next = point_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_total <= '0;
      point_total  <= '0;
    end else if (accept && kind_t'(sample.kind) == KIND_CLEAR) begin
      inside_total <= '0;
      point_total  <= '0;
    end else if (load_result) begin
      inside_total <= inside_next;
      point_total  <= point_next;
    end
  end

  assign bin_ext   = 64'(bin);
  assign total_ext = 64'(byte_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      bin_count     <= (bin_ext > 64'(OUT32_MAX)) ? OUT32_MAX : bin_ext[31:0];
      total_bytes   <= (total_ext > 64'(OUT48_MAX)) ? OUT48_MAX : total_ext[47:0];
      inside_points <= inside_next;
      total_points  <= point_next;
    end
  end

  assign result.valid         = result_valid;
  assign result.bin_count     = bin_count;
  assign result.total_bytes   = total_bytes;
  assign result.inside_points = inside_points;
  assign result.total_points  = total_points;

  `BHMC_ASSERT_NEXT(a_accept_starts_lookup, accept, state == ST_LOOKUP,
                    "accepted item did not start a lookup")
  `BHMC_ASSERT_NOW(a_inside_not_above_points, 1'b1, inside_total <= point_total,
                   "inside count exceeds point count")
  `BHMC_ASSERT_NEXT(a_byte_total_held, state != ST_IDLE, $stable(byte_total),
                    "byte total changed while an item was in flight")
  `BHMC_ASSERT_NEXT(a_group_wraps,
                    accept && sample.kind == KIND_DATA && group_position == GROUP_LAST,
                    group_position == 3'd0, "group position did not wrap after a point")

endmodule
